FILE: design/qkbe_pkg.sv
package qkbe_pkg;

    localparam int CFG_INDEX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_TURN    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 8'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] FAST_TURN_RST    = 16'd50;
    localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [15:0] DOUBLE_CLICK_RST = 16'd300;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;

    // Turn event codes: base direction plus modifier offsets
    localparam logic [3:0] TURN_NONE      = 4'd0;
    localparam logic [3:0] TURN_LEFT      = 4'd1;
    localparam logic [3:0] TURN_RIGHT     = 4'd2;
    localparam logic [3:0] TURN_FAST_OFS  = 4'd2;
    localparam logic [3:0] TURN_PRESS_OFS = 4'd4;

    // Quadrature constants
    localparam logic [1:0] PHASE_DETENT = 2'b11;
    localparam logic [1:0] PHASE_RST    = 2'b11;
    localparam logic [7:0] DETENT_COUNT = 8'd4;

    // Step per transition, indexed by {previous phase, new phase}
    localparam logic [7:0] STEP_TABLE [16] = '{
        8'h00, 8'hFF, 8'h01, 8'h00,
        8'h01, 8'h00, 8'h00, 8'hFF,
        8'hFF, 8'h00, 8'h00, 8'h01,
        8'h00, 8'h01, 8'hFF, 8'h00
    };

    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_SHORT  = 2'd1,
        BTN_DOUBLE = 2'd2,
        BTN_LONG   = 2'd3
    } button_event_t;

    typedef struct packed {
        logic        phase_a;
        logic        phase_b;
        logic        switch_level;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [15:0] fast_turn_ms;
        logic [15:0] debounce_ms;
        logic [15:0] double_click_ms;
        logic [15:0] long_press_ms;
    } cfg_t;

endpackage

FILE: design/qkbe_cfg.sv
module qkbe_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qkbe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    output qkbe_pkg::cfg_t                   cfg
);
    import qkbe_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_turn_ms    <= FAST_TURN_RST;
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
            cfg_reg.double_click_ms <= DOUBLE_CLICK_RST;
            cfg_reg.long_press_ms   <= LONG_PRESS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FAST_TURN:    cfg_reg.fast_turn_ms    <= cfg_data;
                REG_DEBOUNCE:     cfg_reg.debounce_ms     <= cfg_data;
                REG_DOUBLE_CLICK: cfg_reg.double_click_ms <= cfg_data;
                REG_LONG_PRESS:   cfg_reg.long_press_ms   <= cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

endmodule

FILE: design/qkbe_turn.sv
module qkbe_turn (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  qkbe_pkg::sample_t sample,
    input  logic [15:0]       fast_turn_ms,
    output logic [3:0]        turn_event
);
    import qkbe_pkg::*;

    logic [1:0]  last_phase_reg;
    logic [7:0]  step_count_reg;
    logic [31:0] last_detent_reg;

    logic [1:0]  phase;
    logic        phase_change;
    logic [7:0]  step_sum;
    logic        detent;
    logic        fast;
    logic        pressed;
    logic [3:0]  base;

    always_comb begin
        phase        = {sample.phase_b, sample.phase_a};
        pressed      = !sample.switch_level;
        phase_change = (phase != last_phase_reg);
        step_sum     = step_count_reg + STEP_TABLE[{last_phase_reg, phase}];
        detent       = phase_change && (phase == PHASE_DETENT) && (step_sum != 8'd0);
        fast         = (sample.now_ms - last_detent_reg) < {16'd0, fast_turn_ms};
        base         = (step_sum == DETENT_COUNT) ? TURN_LEFT : TURN_RIGHT;
        if (detent) begin
            turn_event = base + (pressed ? TURN_PRESS_OFS : TURN_NONE)
                              + (fast ? TURN_FAST_OFS : TURN_NONE);
        end else begin
            turn_event = TURN_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_phase_reg  <= PHASE_RST;
            step_count_reg  <= 8'd0;
            last_detent_reg <= 32'd0;
        end else if (fire && phase_change) begin
            last_phase_reg <= phase;
            step_count_reg <= detent ? 8'd0 : step_sum;
            if (detent) begin
                last_detent_reg <= sample.now_ms;
            end
        end
    end

    // a detent always leaves the step counter cleared
    a_detent_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && turn_event != TURN_NONE) |=> (step_count_reg == 8'd0))
        else $error("step count not cleared after detent");

endmodule

FILE: design/qkbe_button.sv
module qkbe_button (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fire,
    input  qkbe_pkg::sample_t       sample,
    input  qkbe_pkg::cfg_t          cfg,
    output qkbe_pkg::button_event_t button_event
);
    import qkbe_pkg::*;

    logic [31:0] switch_time_reg;
    logic        held_reg;
    logic        long_reg;
    logic        suppress_reg;
    logic        pending_reg;
    logic        second_reg;
    logic        allowed_reg;

    logic [31:0] elapsed;
    logic        pressed;
    logic        debounced;
    logic        press_acc;
    logic        release_acc;
    logic        edge_acc;
    logic        double_to;
    logic        long_hit;

    always_comb begin
        pressed     = !sample.switch_level;
        elapsed     = sample.now_ms - switch_time_reg;
        debounced   = elapsed > {16'd0, cfg.debounce_ms};
        press_acc   = pressed && !held_reg && debounced;
        release_acc = !pressed && held_reg && debounced;
        edge_acc    = press_acc || release_acc;
        // an accepted edge restarts the timer, so later timeouts see zero
        double_to   = pending_reg && !edge_acc && (elapsed > {16'd0, cfg.double_click_ms});
        long_hit    = held_reg && !long_reg && pressed && !edge_acc &&
                      (elapsed > {16'd0, cfg.long_press_ms});
        if (long_hit) begin
            button_event = BTN_LONG;
        end else if (double_to && second_reg) begin
            button_event = BTN_DOUBLE;
        end else if (release_acc && !suppress_reg) begin
            button_event = BTN_SHORT;
        end else begin
            button_event = BTN_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_time_reg <= 32'd0;
            held_reg        <= 1'b0;
            long_reg        <= 1'b0;
            suppress_reg    <= 1'b0;
            pending_reg     <= 1'b0;
            second_reg      <= 1'b0;
            allowed_reg     <= 1'b0;
        end else if (fire) begin
            if (edge_acc) begin
                switch_time_reg <= sample.now_ms;
            end
            if (press_acc) begin
                held_reg    <= 1'b1;
                long_reg    <= 1'b0;
                allowed_reg <= 1'b1;
            end
            if (release_acc) begin
                held_reg     <= 1'b0;
                suppress_reg <= 1'b0;
                if (allowed_reg && !pending_reg) begin
                    pending_reg <= 1'b1;
                    second_reg  <= 1'b0;
                end else begin
                    second_reg <= 1'b1;
                end
            end
            if (double_to) begin
                pending_reg <= 1'b0;
            end
            if (long_hit) begin
                long_reg     <= 1'b1;
                suppress_reg <= 1'b1;
            end
        end
    end

    // a reported long press masks the following release
    a_long_suppress: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && button_event == BTN_LONG) |=> (suppress_reg && long_reg && held_reg))
        else $error("long press did not arm release suppression");

endmodule

FILE: design/quadrature_knob_and_button_events.sv
// Rotary knob and push switch event decoder. Each input transaction is one
// sample of both quadrature pins, the switch level (0 = pressed) and a free
// running millisecond time; each produces exactly one result transaction
// carrying a turn event (0 none, 1/2 left/right, 3/4 fast left/right,
// 5/6 pressed left/right, 7/8 fast pressed left/right) and a button event
// (0 none, 1 short, 2 double, 3 long). Events are one-sample pulses; the
// press and fast modifiers apply only to the sample on which the detent
// lands. All time gaps are taken modulo 2^32. Throughput is one transaction
// per clock unless m_ready stalls the output. Samples pass the input
// register, the decode logic and the result register. Knob and switch state
// advance as each sample moves from the input register to the result
// register, so results come out strictly in sample order. The config port
// is always ready; write it only while no transaction is in flight.
// Indexes 0..3 select fast_turn_ms, debounce_ms, double_click_ms and
// long_press_ms; other indexes are ignored.
module quadrature_knob_and_button_events (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_phase_a,
    input  logic                             s_phase_b,
    input  logic                             s_switch_level,
    input  logic [31:0]                      s_now_ms,
    // event output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [3:0]                       m_turn_event,
    output logic [1:0]                       m_button_event,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qkbe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);
    import qkbe_pkg::*;

    cfg_t          cfg;
    sample_t       in_sample_reg;
    logic          in_valid_reg;
    logic          m_valid_reg;
    logic [3:0]    m_turn_reg;
    logic [1:0]    m_button_reg;
    logic          advance;
    logic [3:0]    turn_event;
    button_event_t button_event;

    // input register moves on whenever the result register is free or draining
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid        = m_valid_reg;
    assign m_turn_event   = m_turn_reg;
    assign m_button_event = m_button_reg;

    qkbe_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qkbe_turn u_turn (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .sample       (in_sample_reg),
        .fast_turn_ms (cfg.fast_turn_ms),
        .turn_event   (turn_event)
    );

    qkbe_button u_button (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .sample       (in_sample_reg),
        .cfg          (cfg),
        .button_event (button_event)
    );

    // input register: payload without reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg.phase_a      <= s_phase_a;
            in_sample_reg.phase_b      <= s_phase_b;
            in_sample_reg.switch_level <= s_switch_level;
            in_sample_reg.now_ms       <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_turn_reg   <= turn_event;
            m_button_reg <= button_event;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // input side stalls only when both stages hold a transaction and output is blocked
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled while pipeline has room");

    // a processed sample always lands in the result register
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed sample lost before result register");

    // result register never dropped while output is stalled
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("pending result dropped");

endmodule
